// File: sv/smrp_pkg.sv
// ----------------------------------------------------------------------------
// Signed message record parser package
// Phase, tag, status and register index codes shared by the parser.
// ----------------------------------------------------------------------------
package smrp_pkg;

  // Parser phases (state codes)
  localparam logic [2:0] PH_TOKEN  = 3'd0;
  localparam logic [2:0] PH_SENDER = 3'd1;
  localparam logic [2:0] PH_TIME   = 3'd2;
  localparam logic [2:0] PH_TYPE   = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;
  localparam logic [2:0] PH_SIG    = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  // Field tags carried with each byte
  localparam logic [2:0] TAG_TOKEN   = 3'd0;
  localparam logic [2:0] TAG_SENDER  = 3'd1;
  localparam logic [2:0] TAG_TIME    = 3'd2;
  localparam logic [2:0] TAG_TYPE    = 3'd3;
  localparam logic [2:0] TAG_BODY    = 3'd4;
  localparam logic [2:0] TAG_SIG     = 3'd5;
  localparam logic [2:0] TAG_PREFIX  = 3'd6;
  localparam logic [2:0] TAG_DISCARD = 3'd7;

  // Final status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNCATED = 4'd1;
  localparam logic [3:0] ST_BAD_CSIZE = 4'd2;
  localparam logic [3:0] ST_TOO_LARGE = 4'd3;
  localparam logic [3:0] ST_BAD_TIME  = 4'd4;
  localparam logic [3:0] ST_TRAILING  = 4'd5;
  localparam logic [3:0] ST_BAD_SIG   = 4'd6;
  localparam logic [3:0] ST_BAD_FIELD = 4'd7;
  localparam logic [3:0] ST_BAD_TYPE  = 4'd8;
  localparam logic [3:0] ST_BAD_BODY  = 4'd9;

  // Configuration register indexes
  localparam logic [2:0] REG_TOKEN_LIMIT  = 3'd0;
  localparam logic [2:0] REG_SENDER_LIMIT = 3'd1;
  localparam logic [2:0] REG_BODY_LIMIT   = 3'd2;
  localparam logic [2:0] REG_SIG_LIMIT    = 3'd3;
  localparam logic [2:0] REG_PRIV_TYPE    = 3'd4;
  localparam logic [2:0] REG_GROUP_TYPE   = 3'd5;

  // Length prefix markers and the kind of prefix being collected
  localparam logic [7:0] MARK_16 = 8'd253;
  localparam logic [7:0] MARK_32 = 8'd254;
  localparam logic [7:0] MARK_64 = 8'd255;

  localparam logic [1:0] PFX_NONE = 2'd0;
  localparam logic [1:0] PFX_16   = 2'd1;
  localparam logic [1:0] PFX_32   = 2'd2;
  localparam logic [1:0] PFX_64   = 2'd3;

  // Empty field flag bits
  localparam int EMPTY_TOKEN  = 0;
  localparam int EMPTY_SENDER = 1;
  localparam int EMPTY_BODY   = 2;
  localparam int EMPTY_SIG    = 3;

  // Number of timestamp bytes
  localparam logic [31:0] TIME_BYTES = 32'd8;

  // Number of extension bytes that follow a given marker
  function automatic logic [3:0] prefix_need(input logic [1:0] kind);
    logic [3:0] need;
    unique case (kind)
      PFX_16:  need = 4'd2;
      PFX_32:  need = 4'd4;
      default: need = 4'd8;
    endcase
    return need;
  endfunction

endpackage

// File: sv/signed_message_record_parser.sv
// ----------------------------------------------------------------------------
// Signed message record parser
// Tags each byte of a serialised signed message with its field and reports
// the final status of the message on its last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the s_axis channel, tlast marking the final byte of a
//   message. Every byte gives exactly one result on the m_axis channel: the
//   byte, its field tag in tuser, tlast copied through, and a status code
//   that is non-zero only on the result that closes the message.
//   The result is registered, valid in the cycle after the input transfer.
//   Throughput is one byte per cycle while the receiver keeps up; the parser
//   state update for one byte is a single pass ending in the result register.
//   When the receiver stalls, the result register holds its transfer and
//   s_axis_tready drops until the result is taken; no data is lost.
//   Configuration writes (limits and type codes) are always accepted and
//   must only be issued while the parser is idle.
//   Reset returns the limits to their defaults (32, 64, 65536, 72, 1, 2),
//   clears the parser to expect a token length prefix and empties the
//   result register.
// ----------------------------------------------------------------------------
module signed_message_record_parser
  import smrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Byte input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [11:8] status_code, rest zero
  output logic [2:0]  m_axis_tuser,   // [2:0] field_tag
  output logic        m_axis_tlast
);

  // Configuration registers
  logic [15:0] token_limit_q, sender_limit_q, sig_limit_q;
  logic [31:0] body_limit_q;
  logic [7:0]  priv_type_q, group_type_q;

  // Parser state
  logic [2:0]  phase_q, phase_d;
  logic [3:0]  pfx_left_q, pfx_left_d;
  logic [1:0]  pfx_kind_q, pfx_kind_d;
  logic [31:0] acc_q, acc_d;
  logic        acc_hi_q, acc_hi_d;
  logic [31:0] field_left_q, field_left_d;
  logic [3:0]  empty_q, empty_d;
  logic        type_bad_q, type_bad_d;
  logic        trailing_q, trailing_d;
  logic [3:0]  err_q, err_d;

  // Result register
  logic        out_valid_q;
  logic [2:0]  out_tag_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic [3:0]  out_status_q;

  logic        s_fire;
  logic [2:0]  tag;
  logic [3:0]  status;

  // Working signals of the single pass
  logic        enter_en;
  logic [2:0]  enter_ph;
  logic        load_len;
  logic [31:0] len_lo;
  logic        len_hi;
  logic        len_check;
  logic [31:0] limit;
  logic [2:0]  next_ph;
  logic [3:0]  empty_bit;
  logic [3:0]  pfx_idx;
  logic [31:0] acc_new;
  logic        acc_hi_new;
  logic        pfx_bad;
  logic [31:0] time_left;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Configuration register writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_limit_q  <= 16'd32;
      sender_limit_q <= 16'd64;
      body_limit_q   <= 32'd65536;
      sig_limit_q    <= 16'd72;
      priv_type_q    <= 8'd1;
      group_type_q   <= 8'd2;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TOKEN_LIMIT:  token_limit_q  <= cfg_data_i[15:0];
        REG_SENDER_LIMIT: sender_limit_q <= cfg_data_i[15:0];
        REG_BODY_LIMIT:   body_limit_q   <= cfg_data_i;
        REG_SIG_LIMIT:    sig_limit_q    <= cfg_data_i[15:0];
        REG_PRIV_TYPE:    priv_type_q    <= cfg_data_i[7:0];
        REG_GROUP_TYPE:   group_type_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Per-phase limit, successor phase and empty flag
  always_comb begin
    unique case (phase_q)
      PH_TOKEN: begin
        limit     = {16'd0, token_limit_q};
        next_ph   = PH_SENDER;
        empty_bit = 4'b0001 << EMPTY_TOKEN;
      end
      PH_SENDER: begin
        limit     = {16'd0, sender_limit_q};
        next_ph   = PH_TIME;
        empty_bit = 4'b0001 << EMPTY_SENDER;
      end
      PH_BODY: begin
        limit     = body_limit_q;
        next_ph   = PH_SIG;
        empty_bit = 4'b0001 << EMPTY_BODY;
      end
      default: begin
        limit     = {16'd0, sig_limit_q};
        next_ph   = PH_DONE;
        empty_bit = 4'b0001 << EMPTY_SIG;
      end
    endcase
  end

  // Length prefix extension byte merged into the accumulator
  always_comb begin
    pfx_idx    = prefix_need(pfx_kind_q) - pfx_left_q;
    acc_new    = acc_q;
    acc_hi_new = acc_hi_q;
    if (pfx_idx[2]) begin
      acc_hi_new = acc_hi_q || (s_axis_tdata != 8'd0);
    end else begin
      acc_new = acc_q | ({24'd0, s_axis_tdata} << {pfx_idx[1:0], 3'b000});
    end
    unique case (pfx_kind_q)
      PFX_16:  pfx_bad = (acc_new < {24'd0, MARK_16});
      PFX_32:  pfx_bad = (acc_new[31:16] == 16'd0);
      default: pfx_bad = !acc_hi_new;
    endcase
  end

  assign time_left = (field_left_q != 32'd0) ? field_left_q - 32'd1 : field_left_q;

  // Next parser state for the accepted byte
  always_comb begin
    phase_d      = phase_q;
    pfx_left_d   = pfx_left_q;
    pfx_kind_d   = pfx_kind_q;
    acc_d        = acc_q;
    acc_hi_d     = acc_hi_q;
    field_left_d = field_left_q;
    empty_d      = empty_q;
    type_bad_d   = type_bad_q;
    trailing_d   = trailing_q;
    err_d        = err_q;
    tag          = TAG_DISCARD;
    enter_en     = 1'b0;
    enter_ph     = phase_q;
    load_len     = 1'b0;
    len_lo       = {24'd0, s_axis_tdata};
    len_hi       = 1'b0;
    len_check    = 1'b0;

    if (err_q != ST_OK) begin
      tag = TAG_DISCARD;
    end else if (phase_q == PH_DONE) begin
      trailing_d = 1'b1;
      tag        = TAG_DISCARD;
    end else if (phase_q == PH_TIME) begin
      tag          = TAG_TIME;
      field_left_d = time_left;
      if (time_left == 32'd0) begin
        if (s_axis_tdata[7]) begin
          err_d = ST_BAD_TIME;
        end else begin
          enter_en = 1'b1;
          enter_ph = PH_TYPE;
        end
      end
    end else if (phase_q == PH_TYPE) begin
      tag        = TAG_TYPE;
      type_bad_d = (s_axis_tdata != priv_type_q) && (s_axis_tdata != group_type_q);
      enter_en   = 1'b1;
      enter_ph   = PH_BODY;
    end else if (phase_q <= PH_SIG) begin
      // Span phases: prefix extension, field body or a new length prefix
      if (pfx_left_q != 4'd0) begin
        tag        = TAG_PREFIX;
        acc_d      = acc_new;
        acc_hi_d   = acc_hi_new;
        pfx_left_d = pfx_left_q - 4'd1;
        if (pfx_left_q == 4'd1) begin
          if (pfx_bad) begin
            err_d = ST_BAD_CSIZE;
          end else begin
            len_check = 1'b1;
            len_lo    = acc_new;
            len_hi    = acc_hi_new;
          end
        end
      end else if (field_left_q != 32'd0) begin
        tag          = phase_q;
        field_left_d = field_left_q - 32'd1;
        if (field_left_q == 32'd1) begin
          enter_en = 1'b1;
          enter_ph = next_ph;
        end
      end else begin
        tag = TAG_PREFIX;
        if (s_axis_tdata < MARK_16) begin
          len_check = 1'b1;
        end else begin
          pfx_kind_d = (s_axis_tdata == MARK_16) ? PFX_16 :
                       (s_axis_tdata == MARK_32) ? PFX_32 : PFX_64;
          pfx_left_d = prefix_need(pfx_kind_d);
          acc_d      = 32'd0;
          acc_hi_d   = 1'b0;
        end
      end
    end

    // A span length is known: check against the limit and move on
    if (len_check) begin
      if (len_hi || (len_lo > limit)) begin
        err_d = ST_TOO_LARGE;
      end else if (len_lo == 32'd0) begin
        empty_d  = empty_q | empty_bit;
        enter_en = 1'b1;
        enter_ph = next_ph;
      end else begin
        enter_en = 1'b1;
        enter_ph = phase_q;
        load_len = 1'b1;
      end
    end

    // Entering a phase clears the prefix counters and sets the field counter (TIME_BYTES for the timestamp, else zero)
    if (enter_en) begin
      phase_d      = enter_ph;
      pfx_left_d   = 4'd0;
      pfx_kind_d   = PFX_NONE;
      acc_d        = 32'd0;
      acc_hi_d     = 1'b0;
      field_left_d = (enter_ph == PH_TIME) ? TIME_BYTES : 32'd0;
    end
    if (load_len) begin
      field_left_d = len_lo;
    end
  end

  // Final status in priority order, taken from the updated state
  always_comb begin
    priority if (err_d != ST_OK)          status = err_d;
    else if (phase_d != PH_DONE)          status = ST_TRUNCATED;
    else if (trailing_d)                  status = ST_TRAILING;
    else if (empty_d[EMPTY_SIG])          status = ST_BAD_SIG;
    else if (empty_d[EMPTY_TOKEN] || empty_d[EMPTY_SENDER]) status = ST_BAD_FIELD;
    else if (type_bad_d)                  status = ST_BAD_TYPE;
    else if (empty_d[EMPTY_BODY])         status = ST_BAD_BODY;
    else                                  status = ST_OK;
  end

  // Parser state registers; the last byte rearms for a new message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TOKEN;
      pfx_left_q   <= 4'd0;
      pfx_kind_q   <= PFX_NONE;
      acc_q        <= 32'd0;
      acc_hi_q     <= 1'b0;
      field_left_q <= 32'd0;
      empty_q      <= 4'd0;
      type_bad_q   <= 1'b0;
      trailing_q   <= 1'b0;
      err_q        <= ST_OK;
    end else if (s_fire) begin
      if (s_axis_tlast) begin
        phase_q      <= PH_TOKEN;
        pfx_left_q   <= 4'd0;
        pfx_kind_q   <= PFX_NONE;
        acc_q        <= 32'd0;
        acc_hi_q     <= 1'b0;
        field_left_q <= 32'd0;
        empty_q      <= 4'd0;
        type_bad_q   <= 1'b0;
        trailing_q   <= 1'b0;
        err_q        <= ST_OK;
      end else begin
        phase_q      <= phase_d;
        pfx_left_q   <= pfx_left_d;
        pfx_kind_q   <= pfx_kind_d;
        acc_q        <= acc_d;
        acc_hi_q     <= acc_hi_d;
        field_left_q <= field_left_d;
        empty_q      <= empty_d;
        type_bad_q   <= type_bad_d;
        trailing_q   <= trailing_d;
        err_q        <= err_d;
      end
    end
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_tag_q    <= tag;
      out_byte_q   <= s_axis_tdata;
      out_last_q   <= s_axis_tlast;
      out_status_q <= s_axis_tlast ? status : ST_OK;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_status_q, out_byte_q};
  assign m_axis_tuser  = out_tag_q;
  assign m_axis_tlast  = out_last_q;

endmodule
